// ===== sv/rhh_pkg.sv =====
package rhh_pkg;

    localparam int TABLE_SLOTS = 729;
    localparam int KEY_CHARS   = 8;
    localparam int VALUE_BITS  = 32;

    localparam int SLOT_AW   = $clog2(TABLE_SLOTS);
    localparam int SIZE_W    = $clog2(TABLE_SLOTS + 1);
    localparam int DIST_W    = SIZE_W + 1;
    localparam int KEY_W     = 8 * KEY_CHARS;
    localparam int LEN_W     = 4;
    localparam int CFG_W     = 10;
    localparam int CNT_W     = 10;
    localparam int HASH_W    = 64;
    localparam int VAL_IO_W  = 32;
    localparam int MIN_SLOTS = 3;
    localparam int HASH_MUL  = 131;

    // operation codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_ERASE  = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ABSENT  = 2'd1;
    localparam logic [1:0] ST_PRESENT = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_SLOTS = 2'd0;
    localparam logic [1:0] CFG_MAX   = 2'd1;

    typedef struct packed {
        logic [1:0]          op;
        logic [KEY_W-1:0]    key_chars;
        logic [LEN_W-1:0]    key_length;
        logic [VAL_IO_W-1:0] value_in;
    } t_req;

    typedef struct packed {
        logic [1:0]          status;
        logic [VAL_IO_W-1:0] value_out;
        logic [CNT_W-1:0]    entry_count;
    } t_rsp;

    typedef struct packed {
        logic                  valid;
        logic [LEN_W-1:0]      len;
        logic [DIST_W-1:0]     disp;
        logic [KEY_W-1:0]      key;
        logic [VALUE_BITS-1:0] value;
    } t_slot;

    // table size in use, clamped to the legal range
    function automatic logic [SIZE_W-1:0] live_size(input logic [CFG_W-1:0] cfg);
        logic [31:0] s;
        s = 32'(cfg);
        if (s < 32'(MIN_SLOTS)) s = 32'(MIN_SLOTS);
        if (s > 32'(TABLE_SLOTS)) s = 32'(TABLE_SLOTS);
        return SIZE_W'(s);
    endfunction

    // load limit, keeps one slot empty
    function automatic logic [SIZE_W-1:0] live_limit(input logic [CFG_W-1:0] lim,
                                                     input logic [SIZE_W-1:0] size);
        logic [31:0] l;
        logic [31:0] cap;
        l   = 32'(lim);
        cap = 32'(size) - 32'd1;
        return SIZE_W'((l > cap) ? cap : l);
    endfunction

    // linear probe step with wrap
    function automatic logic [SLOT_AW-1:0] next_slot(input logic [SLOT_AW-1:0] p,
                                                     input logic [SIZE_W-1:0] size);
        logic [31:0] q;
        q = 32'(p) + 32'd1;
        return (q >= 32'(size)) ? '0 : SLOT_AW'(q);
    endfunction

endpackage

// ===== sv/rhh_ram.sv =====
module rhh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== sv/rhh_hash.sv =====
module rhh_hash (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [rhh_pkg::KEY_W-1:0]  i_chars,
    input  logic [rhh_pkg::LEN_W-1:0]  i_len,
    output logic                      o_done,
    output logic [rhh_pkg::KEY_W-1:0]  o_key,
    output logic [rhh_pkg::HASH_W-1:0] o_hash
);
    import rhh_pkg::*;

    localparam int IDX_W = (KEY_CHARS > 1) ? $clog2(KEY_CHARS) : 1;

    logic              r_busy;
    logic              r_done;
    logic [IDX_W-1:0]  r_idx;
    logic [KEY_W-1:0]  r_key;
    logic [HASH_W-1:0] r_hash;
    logic [7:0]        w_c;
    logic              w_active;
    logic              w_last;

    // one character per cycle, lowered
    always_comb begin
        w_c = i_chars[8*r_idx +: 8];
        if (w_c >= 8'h41 && w_c <= 8'h5A) w_c = w_c + 8'h20;
        w_active = 32'(r_idx) < 32'(i_len);
        w_last   = 32'(r_idx) == KEY_CHARS - 1;
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_done <= r_busy && w_last;
            if (i_start) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (r_busy) begin
                if (w_last) r_busy <= 1'b0;
                else r_idx <= r_idx + 1'b1;
            end
        end
    end

    // h = h*131 + c as shifts and adds
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_key  <= '0;
            r_hash <= '0;
        end else if (r_busy && w_active) begin
            r_key[8*r_idx +: 8] <= w_c;
            r_hash <= (r_hash << 7) + (r_hash << 1) + r_hash + HASH_W'(w_c);
        end
    end

    assign o_done = r_done;
    assign o_key  = r_key;
    assign o_hash = r_hash;
endmodule

// ===== sv/rhh_mod.sv =====
module rhh_mod (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [rhh_pkg::HASH_W-1:0] i_dividend,
    input  logic [rhh_pkg::SIZE_W-1:0] i_divisor,
    output logic                      o_done,
    output logic [rhh_pkg::SIZE_W-1:0] o_rem
);
    import rhh_pkg::*;

    localparam int BITS_PER = 4;
    localparam int STEPS    = HASH_W / BITS_PER;
    localparam int CNT_BW   = $clog2(STEPS);

    logic              r_busy;
    logic              r_done;
    logic [CNT_BW-1:0] r_cnt;
    logic [SIZE_W-1:0] r_rem;
    logic [HASH_W-1:0] r_dvd;
    logic [SIZE_W:0]   w_t;
    logic [SIZE_W-1:0] w_rem;

    // four restoring steps per cycle on the narrow remainder
    always_comb begin
        w_rem = r_rem;
        w_t   = '0;
        for (int k = 0; k < BITS_PER; k++) begin
            w_t = {w_rem, r_dvd[HASH_W-1-k]};
            if (w_t >= {1'b0, i_divisor}) w_t = w_t - {1'b0, i_divisor};
            w_rem = w_t[SIZE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (32'(r_cnt) == STEPS - 1);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (32'(r_cnt) == STEPS - 1) r_busy <= 1'b0;
                else r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_rem;
            r_dvd <= r_dvd << BITS_PER;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;
endmodule

// ===== sv/robin_hood_hash_map_unit.sv =====
// channel   direction  handshake                  payload
// request   in         i_in_valid / o_in_ready    i_in_req  (op, key, length, value)
// response  out        o_out_valid / i_out_ready  o_out_rsp (status, value, count)
// config    in         i_cfg_we                   i_cfg_index, i_cfg_data
//
// an item is hashed, reduced modulo the table size (4 bits a cycle),
// then probed slot by slot; insert and erase move slots one at a time
// through the single slot memory (one read and one write port)
// reset, a clear request and a write of slots_in_use run a clearing pass over
// all 729 slots of the slot memory; no request is taken meanwhile
// one request is worked at a time; a new request is taken while the
// previous response still waits in the output register
module robin_hood_hash_map_unit (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  rhh_pkg::t_req            i_in_req,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output rhh_pkg::t_rsp            o_out_rsp,
    input  logic                     i_cfg_we,
    input  logic [1:0]               i_cfg_index,
    input  logic [rhh_pkg::CFG_W-1:0] i_cfg_data
);
    import rhh_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_HASH = 4'd1;
    localparam logic [3:0] S_MOD  = 4'd2;
    localparam logic [3:0] S_PRD  = 4'd3;
    localparam logic [3:0] S_PCHK = 4'd4;
    localparam logic [3:0] S_IRD  = 4'd5;
    localparam logic [3:0] S_ICHK = 4'd6;
    localparam logic [3:0] S_ERD  = 4'd7;
    localparam logic [3:0] S_ECHK = 4'd8;
    localparam logic [3:0] S_CLR  = 4'd9;
    localparam logic [3:0] S_DONE = 4'd10;

    logic [3:0]            r_state, n_state;
    t_req                  r_req;
    logic [LEN_W-1:0]      r_len;
    logic [SLOT_AW-1:0]    r_pos, n_pos;
    logic [SLOT_AW-1:0]    r_nxt, n_nxt;
    logic [DIST_W-1:0]     r_dist, n_dist;
    logic [DIST_W-1:0]     r_steps, n_steps;
    logic [KEY_W-1:0]      r_ck, n_ck;
    logic [VALUE_BITS-1:0] r_cv, n_cv;
    logic [LEN_W-1:0]      r_cl, n_cl;
    logic [DIST_W-1:0]     r_cd, n_cd;
    logic [SIZE_W-1:0]     r_count, n_count;
    logic [CFG_W-1:0]      r_size_cfg, n_size_cfg;
    logic [CFG_W-1:0]      r_max_cfg, n_max_cfg;
    logic [SLOT_AW-1:0]    r_clr_addr, n_clr_addr;
    logic                  r_clr_out, n_clr_out;
    logic [1:0]            r_status, n_status;
    logic [VAL_IO_W-1:0]   r_vout, n_vout;
    logic                  r_out_valid, n_out_valid;
    t_rsp                  r_out, n_out;

    logic                  w_accept;
    logic [SIZE_W-1:0]     w_size;
    logic [SIZE_W-1:0]     w_limit;
    logic                  w_hash_done;
    logic [KEY_W-1:0]      w_key;
    logic [HASH_W-1:0]     w_hash;
    logic                  w_mod_done;
    logic [SIZE_W-1:0]     w_home;
    logic                  w_match;
    logic                  w_hit;
    logic [DIST_W-1:0]     w_steps1;

    logic                  ram_we;
    logic [SLOT_AW-1:0]    ram_waddr;
    logic [SLOT_AW-1:0]    ram_raddr;
    t_slot                 ram_wdata;
    t_slot                 ram_rdata;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_size     = live_size(r_size_cfg);
    assign w_limit    = live_limit(r_max_cfg, w_size);

    rhh_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept && (i_in_req.op != OP_CLEAR)),
        .i_chars (r_req.key_chars),
        .i_len   (r_len),
        .o_done  (w_hash_done),
        .o_key   (w_key),
        .o_hash  (w_hash)
    );

    rhh_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    ((r_state == S_HASH) && w_hash_done),
        .i_dividend (w_hash),
        .i_divisor  (w_size),
        .o_done     (w_mod_done),
        .o_rem      (w_home)
    );

    rhh_ram #(
        .WIDTH ($bits(t_slot)),
        .DEPTH (TABLE_SLOTS)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // slot compare against the key being worked
    always_comb begin
        w_match  = (ram_rdata.len == r_len) && (ram_rdata.key == w_key);
        w_hit    = ram_rdata.valid && (ram_rdata.disp == r_dist) && w_match;
        w_steps1 = r_steps + 1'b1;
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_nxt       = r_nxt;
        n_dist      = r_dist;
        n_steps     = r_steps;
        n_ck        = r_ck;
        n_cv        = r_cv;
        n_cl        = r_cl;
        n_cd        = r_cd;
        n_count     = r_count;
        n_size_cfg  = r_size_cfg;
        n_max_cfg   = r_max_cfg;
        n_clr_addr  = r_clr_addr;
        n_clr_out   = r_clr_out;
        n_status    = r_status;
        n_vout      = r_vout;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        ram_we      = 1'b0;
        ram_waddr   = r_pos;
        ram_wdata   = '0;
        ram_raddr   = r_pos;

        // output register drains independently
        if (r_out_valid && i_out_ready) n_out_valid = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_status = ST_OK;
                    n_vout   = '0;
                    if (i_in_req.op == OP_CLEAR) begin
                        n_count    = '0;
                        n_clr_addr = '0;
                        n_clr_out  = 1'b1;
                        n_state    = S_CLR;
                    end else begin
                        n_state = S_HASH;
                    end
                end
            end
            S_HASH: begin
                if (w_hash_done) n_state = S_MOD;
            end
            S_MOD: begin
                if (w_mod_done) begin
                    n_pos   = SLOT_AW'(w_home);
                    n_dist  = '0;
                    n_state = S_PRD;
                end
            end
            S_PRD: begin
                // probe ran over the whole table
                if (r_dist >= {1'b0, w_size}) begin
                    n_status = (r_req.op == OP_INSERT) ? ST_FULL : ST_ABSENT;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_PCHK;
                end
            end
            S_PCHK: begin
                if (!ram_rdata.valid || (ram_rdata.disp < r_dist) || w_match) begin
                    n_state = S_DONE;
                    case (r_req.op)
                        OP_LOOKUP: begin
                            if (w_hit) n_vout = VAL_IO_W'(ram_rdata.value);
                            else n_status = ST_ABSENT;
                        end
                        OP_ERASE: begin
                            if (!w_hit) begin
                                n_status = ST_ABSENT;
                            end else begin
                                n_count = r_count - 1'b1;
                                n_nxt   = next_slot(r_pos, w_size);
                                n_steps = '0;
                                n_state = S_ERD;
                            end
                        end
                        default: begin
                            if (w_hit) begin
                                n_status = ST_PRESENT;
                            end else if ({1'b0, r_count} + 1'b1 > {1'b0, w_limit}) begin
                                n_status = ST_FULL;
                            end else begin
                                n_count = r_count + 1'b1;
                                n_ck    = w_key;
                                n_cv    = VALUE_BITS'(r_req.value_in);
                                n_cl    = r_len;
                                n_cd    = r_dist;
                                n_steps = '0;
                                n_state = S_IRD;
                            end
                        end
                    endcase
                end else begin
                    n_dist  = r_dist + 1'b1;
                    n_pos   = next_slot(r_pos, w_size);
                    n_state = S_PRD;
                end
            end
            S_IRD: begin
                n_state = S_ICHK;
            end
            S_ICHK: begin
                ram_wdata = '{valid: 1'b1, len: r_cl, disp: r_cd, key: r_ck, value: r_cv};
                if (!ram_rdata.valid) begin
                    ram_we  = 1'b1;
                    n_state = S_DONE;
                end else begin
                    // displace a richer entry and carry it on
                    if (ram_rdata.disp < r_cd) begin
                        ram_we = 1'b1;
                        n_ck   = ram_rdata.key;
                        n_cv   = ram_rdata.value;
                        n_cl   = ram_rdata.len;
                        n_cd   = ram_rdata.disp + 1'b1;
                    end else begin
                        n_cd = r_cd + 1'b1;
                    end
                    n_steps = w_steps1;
                    if (w_steps1 > {1'b0, w_size}) begin
                        n_state = S_DONE;
                    end else begin
                        n_pos   = next_slot(r_pos, w_size);
                        n_state = S_IRD;
                    end
                end
            end
            S_ERD: begin
                ram_raddr = r_nxt;
                n_state   = S_ECHK;
            end
            S_ECHK: begin
                // backward shift
                if (ram_rdata.valid && (ram_rdata.disp != '0) &&
                    (r_steps < {1'b0, w_size})) begin
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata;
                    ram_wdata.disp = ram_rdata.disp - 1'b1;
                    n_pos     = r_nxt;
                    n_nxt     = next_slot(r_nxt, w_size);
                    n_steps   = w_steps1;
                    n_state   = S_ERD;
                end else begin
                    ram_we  = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_CLR: begin
                ram_we     = 1'b1;
                ram_waddr  = r_clr_addr;
                n_clr_addr = r_clr_addr + 1'b1;
                if (32'(r_clr_addr) == TABLE_SLOTS - 1) begin
                    n_state = r_clr_out ? S_DONE : S_IDLE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out       = '{status: r_status, value_out: r_vout,
                                    entry_count: CNT_W'(r_count)};
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // configuration writes
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SLOTS: begin
                    n_size_cfg = i_cfg_data;
                    n_count    = '0;
                    n_clr_addr = '0;
                    n_clr_out  = 1'b0;
                    n_state    = S_CLR;
                end
                CFG_MAX: begin
                    n_max_cfg = i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_addr  <= '0;
            r_clr_out   <= 1'b0;
            r_count     <= '0;
            r_size_cfg  <= CFG_W'(TABLE_SLOTS);
            r_max_cfg   <= CFG_W'(TABLE_SLOTS - 1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_clr_out   <= n_clr_out;
            r_count     <= n_count;
            r_size_cfg  <= n_size_cfg;
            r_max_cfg   <= n_max_cfg;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_in_req;
            r_len <= (i_in_req.key_length > LEN_W'(KEY_CHARS)) ?
                     LEN_W'(KEY_CHARS) : i_in_req.key_length;
        end
        r_pos    <= n_pos;
        r_nxt    <= n_nxt;
        r_dist   <= n_dist;
        r_steps  <= n_steps;
        r_ck     <= n_ck;
        r_cv     <= n_cv;
        r_cl     <= n_cl;
        r_cd     <= n_cd;
        r_status <= n_status;
        r_vout   <= n_vout;
        r_out    <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;

`ifndef NO_ASSERTIONS
    a_count_below_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count < w_size)
        else $error("entry count reached table size");
    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_CLR || r_state == S_ICHK || r_state == S_ECHK))
        else $error("slot write outside a write state");
    a_probe_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PCHK) |-> (r_dist < {1'b0, w_size}))
        else $error("probe distance beyond table size");
`endif
endmodule
